// ===== design/rmh_pkg.sv =====
package rmh_pkg;

    // Operation applied to a whole row of cells at once.
    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_SHIFT
    } chain_op_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_REBAL,
        ST_DONE
    } rmh_state_t;

endpackage

// ===== design/rmh_cell.sv =====
module rmh_cell #(
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  rmh_pkg::chain_op_t       op,
    input  logic signed [WIDTH-1:0]  din,
    input  logic signed [WIDTH-1:0]  left_val,
    input  logic                     left_keep,
    input  logic signed [WIDTH-1:0]  right_val,
    input  logic                     occ,
    output logic signed [WIDTH-1:0]  val,
    output logic                     keep
);
    import rmh_pkg::*;

    logic signed [WIDTH-1:0] val_reg;
    logic signed [WIDTH-1:0] val_next;

    // The cell keeps its value on insert when it is occupied and not below the new value.
    assign keep = occ && (val_reg >= din);
    assign val  = val_reg;

    // Next value: keep, take the new value, take the left neighbor, or take the right one.
    always_comb
    begin
        case (op)
            CH_INSERT:
            begin
                if (keep)
                    val_next = val_reg;
                else if (left_keep)
                    val_next = din;
                else
                    val_next = left_val;
            end
            CH_SHIFT:  val_next = right_val;
            default:   val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== design/rmh_chain.sv =====
module rmh_chain #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32,
    parameter int CW    = 10
) (
    input  logic                     clk,
    input  rmh_pkg::chain_op_t       op,
    input  logic signed [WIDTH-1:0]  din,
    input  logic [CW-1:0]            count,
    output logic signed [WIDTH-1:0]  top
);
    import rmh_pkg::*;

    logic signed [WIDTH-1:0] vals  [DEPTH];
    logic                    keeps [DEPTH];

    // A row of cells sorted in descending order; cell zero holds the largest entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WIDTH-1:0] lv;
        logic                    lk;
        logic signed [WIDTH-1:0] rv;

        if (i == 0)
        begin : g_first
            assign lv = din;
            assign lk = 1'b1;
        end
        else
        begin : g_mid
            assign lv = vals[i-1];
            assign lk = keeps[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rv = vals[i];
        end
        else
        begin : g_inner
            assign rv = vals[i+1];
        end

        rmh_cell #(
            .WIDTH(WIDTH)
        ) u_cell (
            .clk      (clk),
            .op       (op),
            .din      (din),
            .left_val (lv),
            .left_keep(lk),
            .right_val(rv),
            .occ      (CW'(i) < count),
            .val      (vals[i]),
            .keep     (keeps[i])
        );
    end

    assign top = vals[0];

endmodule

// ===== design/running_median_two_heaps.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    sample, start_req
// out      output     out_valid/out_ready  median, dropped
//
// Each sample passes through the steps accept, insert into one cell row, rebalance
// (pop one row while pushing into the other), and forming the median.
// Every row operation is applied to all cells of the row together, as all cells shift at once.
// Reset clears both counts; cell contents need no clearing.
// A result waits in the output register while the next sample is accepted;
// the sequencer only stalls in its last state until that register is free.
module running_median_two_heaps #(
    parameter int HEAP_DEPTH   = 512,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           start_req,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] median,
    output logic                           dropped
);
    import rmh_pkg::*;

    localparam int W  = SAMPLE_WIDTH;
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    rmh_state_t state_reg, state_next;

    logic signed [W-1:0] sample_reg, sample_next;
    logic [CW-1:0]       lc_reg, lc_next, uc_reg, uc_next;
    logic                drop_reg, drop_next;
    logic signed [W-1:0] median_reg, median_next;
    logic                odrop_reg, odrop_next;
    logic                out_valid_reg, out_valid_next;

    chain_op_t           lower_op, upper_op;
    logic signed [W-1:0] lower_din, upper_din;
    logic signed [W-1:0] lower_top, upper_raw, upper_top;

    logic signed [W:0]   sum;
    logic signed [W:0]   sum_adj;
    logic                to_lower;

    // Lower half: descending row. Upper half: stored inverted, so its max is the min.
    rmh_chain #(.DEPTH(HEAP_DEPTH), .WIDTH(W), .CW(CW)) u_lower (
        .clk(clk), .op(lower_op), .din(lower_din), .count(lc_reg), .top(lower_top)
    );

    rmh_chain #(.DEPTH(HEAP_DEPTH), .WIDTH(W), .CW(CW)) u_upper (
        .clk(clk), .op(upper_op), .din(upper_din), .count(uc_reg), .top(upper_raw)
    );

    assign upper_top = ~upper_raw;
    assign to_lower  = (lc_reg == '0) || !(sample_reg > lower_top);

    // Average of the two tops, truncated toward zero.
    assign sum     = {lower_top[W-1], lower_top} + {upper_top[W-1], upper_top};
    assign sum_adj = sum + (W+1)'(sum[W] & sum[0]);

    // Next state.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = in_valid ? ST_INSERT : ST_IDLE;
            ST_INSERT: state_next = ST_REBAL;
            ST_REBAL:  state_next = ST_DONE;
            ST_DONE:   state_next = (!out_valid_reg || out_ready) ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and output control per state.
    always_comb
    begin
        sample_next    = sample_reg;
        lc_next        = lc_reg;
        uc_next        = uc_reg;
        drop_next      = drop_reg;
        median_next    = median_reg;
        odrop_next     = odrop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        lower_op       = CH_HOLD;
        upper_op       = CH_HOLD;
        lower_din      = sample_reg;
        upper_din      = ~sample_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    drop_next   = 1'b0;
                    if (start_req)
                    begin
                        lc_next = '0;
                        uc_next = '0;
                    end
                end
            end
            ST_INSERT:
            begin
                if (to_lower)
                begin
                    if (lc_reg == CW'(HEAP_DEPTH))
                        drop_next = 1'b1;
                    else
                    begin
                        lower_op = CH_INSERT;
                        lc_next  = lc_reg + CW'(1);
                    end
                end
                else
                begin
                    if (uc_reg == CW'(HEAP_DEPTH))
                        drop_next = 1'b1;
                    else
                    begin
                        upper_op = CH_INSERT;
                        uc_next  = uc_reg + CW'(1);
                    end
                end
            end
            ST_REBAL:
            begin
                if (!drop_reg)
                begin
                    if ({1'b0, lc_reg} == {1'b0, uc_reg} + (CW+1)'(2))
                    begin
                        lower_op  = CH_SHIFT;
                        upper_op  = CH_INSERT;
                        upper_din = ~lower_top;
                        lc_next   = lc_reg - CW'(1);
                        uc_next   = uc_reg + CW'(1);
                    end
                    else if ({1'b0, uc_reg} == {1'b0, lc_reg} + (CW+1)'(2))
                    begin
                        upper_op  = CH_SHIFT;
                        lower_op  = CH_INSERT;
                        lower_din = upper_top;
                        uc_next   = uc_reg - CW'(1);
                        lc_next   = lc_reg + CW'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    odrop_next     = drop_reg;
                    if (lc_reg == uc_reg)
                        median_next = sum_adj[W:1];
                    else if (lc_reg > uc_reg)
                        median_next = lower_top;
                    else
                        median_next = upper_top;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lc_reg        <= '0;
            uc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lc_reg        <= lc_next;
            uc_reg        <= uc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        drop_reg   <= drop_next;
        median_reg <= median_next;
        odrop_reg  <= odrop_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign dropped   = odrop_reg;

    // Neither count can pass the row length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (lc_reg <= CW'(HEAP_DEPTH)) && (uc_reg <= CW'(HEAP_DEPTH)))
        else $error("heap count beyond depth");

    // Between samples the halves differ by at most one entry.
    a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
        ((lc_reg == uc_reg) || ({1'b0, lc_reg} == {1'b0, uc_reg} + (CW+1)'(1)) ||
         ({1'b0, uc_reg} == {1'b0, lc_reg} + (CW+1)'(1))))
        else $error("heaps out of balance");

    // A sample is dropped only when a heap is full.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REBAL && drop_reg) |->
        ((lc_reg == CW'(HEAP_DEPTH)) || (uc_reg == CW'(HEAP_DEPTH))))
        else $error("drop without a full heap");

endmodule

// ===== tb/running_median_two_heaps_tb.sv =====
module running_median_two_heaps_tb;

    localparam int DEPTH = 512;
    localparam int SW    = 32;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 start_req;
    } sample_txn_t;

    typedef struct packed {
        logic signed [SW-1:0] median;
        logic                 dropped;
    } median_txn_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [SW-1:0] sample;
    logic                 start_req;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [SW-1:0] median;
    logic                 dropped;

    running_median_two_heaps #(
        .HEAP_DEPTH  (DEPTH),
        .SAMPLE_WIDTH(SW)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .start_req(start_req),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .median   (median),
        .dropped  (dropped)
    );

    // Predictor state: the two heaps and their fill counts.
    logic signed [SW-1:0] low_heap [DEPTH];
    logic signed [SW-1:0] high_heap[DEPTH];
    int                   low_cnt;
    int                   high_cnt;

    sample_txn_t pending_samples[$];
    median_txn_t expected_medians[$];
    int          mismatch_count = 0;
    int          sent_count = 0;
    int          got_count = 0;
    int          drop_count = 0;
    int          start_count = 0;
    int          in_gap;
    int          out_gap;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(20, 60);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    // True when a belongs above b: max-heap when is_max, else min-heap.
    function automatic bit ranks_above(bit is_max, logic signed [SW-1:0] a,
                                       logic signed [SW-1:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic push_low(logic signed [SW-1:0] v);
        int c;
        int p;
        logic signed [SW-1:0] t;
        c = low_cnt;
        low_heap[c] = v;
        low_cnt++;
        while (c > 0)
        begin
            p = (c - 1) / 2;
            if (!ranks_above(1'b1, low_heap[c], low_heap[p]))
            begin
                break;
            end
            t = low_heap[p];
            low_heap[p] = low_heap[c];
            low_heap[c] = t;
            c = p;
        end
    endtask

    task automatic push_high(logic signed [SW-1:0] v);
        int c;
        int p;
        logic signed [SW-1:0] t;
        c = high_cnt;
        high_heap[c] = v;
        high_cnt++;
        while (c > 0)
        begin
            p = (c - 1) / 2;
            if (!ranks_above(1'b0, high_heap[c], high_heap[p]))
            begin
                break;
            end
            t = high_heap[p];
            high_heap[p] = high_heap[c];
            high_heap[c] = t;
            c = p;
        end
    endtask

    task automatic pop_low(output logic signed [SW-1:0] top);
        int n;
        int p;
        int l;
        int best;
        logic signed [SW-1:0] t;
        top = low_heap[0];
        n = low_cnt - 1;
        low_heap[0] = low_heap[n];
        low_cnt = n;
        p = 0;
        forever
        begin
            l = 2 * p + 1;
            best = p;
            if (l < n && ranks_above(1'b1, low_heap[l], low_heap[best]))
            begin
                best = l;
            end
            if (l + 1 < n && ranks_above(1'b1, low_heap[l + 1], low_heap[best]))
            begin
                best = l + 1;
            end
            if (best == p)
            begin
                break;
            end
            t = low_heap[p];
            low_heap[p] = low_heap[best];
            low_heap[best] = t;
            p = best;
        end
    endtask

    task automatic pop_high(output logic signed [SW-1:0] top);
        int n;
        int p;
        int l;
        int best;
        logic signed [SW-1:0] t;
        top = high_heap[0];
        n = high_cnt - 1;
        high_heap[0] = high_heap[n];
        high_cnt = n;
        p = 0;
        forever
        begin
            l = 2 * p + 1;
            best = p;
            if (l < n && ranks_above(1'b0, high_heap[l], high_heap[best]))
            begin
                best = l;
            end
            if (l + 1 < n && ranks_above(1'b0, high_heap[l + 1], high_heap[best]))
            begin
                best = l + 1;
            end
            if (best == p)
            begin
                break;
            end
            t = high_heap[p];
            high_heap[p] = high_heap[best];
            high_heap[best] = t;
            p = best;
        end
    endtask

    // Insert one sample, rebalance and form the running median.
    task automatic predict_median(sample_txn_t txn);
        median_txn_t res;
        logic signed [SW-1:0] moved;
        logic signed [SW:0]   sum;
        res.dropped = 1'b0;
        if (txn.start_req)
        begin
            low_cnt = 0;
            high_cnt = 0;
        end
        if (low_cnt == 0 || !(txn.sample > low_heap[0]))
        begin
            if (low_cnt >= DEPTH)
            begin
                res.dropped = 1'b1;
            end
            else
            begin
                push_low(txn.sample);
            end
        end
        else
        begin
            if (high_cnt >= DEPTH)
            begin
                res.dropped = 1'b1;
            end
            else
            begin
                push_high(txn.sample);
            end
        end
        if (!res.dropped)
        begin
            if (low_cnt == high_cnt + 2)
            begin
                pop_low(moved);
                push_high(moved);
            end
            else if (high_cnt == low_cnt + 2)
            begin
                pop_high(moved);
                push_low(moved);
            end
        end
        if (low_cnt == high_cnt)
        begin
            // Empty heaps after a drop cannot happen, so both tops are written.
            sum = {low_heap[0][SW-1], low_heap[0]} + {high_heap[0][SW-1], high_heap[0]};
            sum = sum / 2;
            res.median = sum[SW-1:0];
        end
        else if (low_cnt > high_cnt)
        begin
            res.median = low_heap[0];
        end
        else
        begin
            res.median = high_heap[0];
        end
        expected_medians = {expected_medians, res};
    endtask

    task automatic report_mismatch(string what, logic [SW-1:0] got, logic [SW-1:0] exp);
        $display("Mismatch on %s at result %0d: got %0h expected %0h", what, got_count, got,
                 exp);
        mismatch_count++;
    endtask

    // Driver: present queued samples with random gaps between transactions.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
            start_req <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_median({sample, start_req});
                sent_count++;
                if (start_req)
                begin
                    start_count++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    {sample, start_req} <= pending_samples.pop_front();
                    in_valid <= 1'b1;
                    in_gap <= gap_length();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    report_mismatch("unexpected result", median, '0);
                end
                else
                begin
                    median_txn_t exp;
                    exp = expected_medians.pop_front();
                    if (median !== exp.median)
                    begin
                        report_mismatch("median", median, exp.median);
                    end
                    if (dropped !== exp.dropped)
                    begin
                        report_mismatch("dropped", SW'(dropped), SW'(exp.dropped));
                    end
                    if (exp.dropped)
                    begin
                        drop_count++;
                    end
                end
                got_count++;
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    out_gap <= gap_length();
                end
            end
        end
    end

    function automatic sample_txn_t make_txn(logic signed [SW-1:0] v, bit st);
        sample_txn_t t;
        t.sample = v;
        t.start_req = st;
        return t;
    endfunction

    // Append one sample transaction to the driver queue.
    task automatic add_sample(logic signed [SW-1:0] v, bit st);
        pending_samples = {pending_samples, make_txn(v, st)};
    endtask

    // Random value: mostly narrow ranges to force duplicates, some full range.
    function automatic logic signed [SW-1:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $signed($urandom_range(0, 20)) - 10;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                           : 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    initial
    begin
        int len;
        int total;
        logic signed [SW-1:0] base;
        rst_n = 1'b0;

        // Directed: extremes, ties with the lower top, averaging signs.
        add_sample(32'sh7fffffff, 1'b1);
        add_sample(32'sh7fffffff, 1'b0);
        add_sample(32'sh80000000, 1'b1);
        add_sample(32'sh80000000, 1'b0);
        add_sample(32'sh7fffffff, 1'b0);
        add_sample(-3, 1'b1);
        add_sample(0, 1'b0);
        add_sample(3, 1'b1);
        add_sample(0, 1'b0);
        add_sample(5, 1'b1);
        add_sample(5, 1'b0);
        add_sample(5, 1'b0);
        add_sample(1, 1'b0);
        add_sample(9, 1'b0);
        add_sample(32'sh55555555, 1'b0);
        add_sample(32'shaaaaaaaa, 1'b0);
        add_sample(-1, 1'b0);

        // Full heaps: fill both halves to capacity with small values.
        add_sample(7, 1'b1);
        for (int i = 0; i < 2 * DEPTH - 1; i++)
        begin
            add_sample($signed($urandom_range(0, 2000)) - 1000, 1'b0);
        end
        // Samples for either half are now dropped.
        for (int i = 0; i < 3; i++)
        begin
            add_sample(32'sh80000000, 1'b0);
            add_sample(32'sh7fffffff, 1'b0);
        end
        // Start after full heaps.
        add_sample(-8, 1'b1);
        total = pending_samples.size();

        // Random sequences of mostly short length with random content.
        while (total < 1100)
        begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(30, 120) : $urandom_range(1, 12);
            base = rand_value();
            for (int i = 0; i < len; i++)
            begin
                add_sample($urandom_range(0, 3) == 0 ? base : rand_value(),
                           i == 0 ? 1'b1 : ($urandom_range(0, 40) == 0));
            end
            total += len;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_samples.size() == 0 && !in_valid);
        wait (expected_medians.size() == 0);
        repeat (20) @(posedge clk);
        $display("Sent %0d samples in %0d sequences, checked %0d medians.",
                 sent_count, start_count, got_count);
        $display("Full heaps dropped %0d samples; random gaps stalled both channels.",
                 drop_count);
        if (mismatch_count == 0 && expected_medians.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", expected_medians.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rmh_pkg.sv
design/rmh_cell.sv
design/rmh_chain.sv
design/running_median_two_heaps.sv
tb/running_median_two_heaps_tb.sv
